// File: design/sle_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and line-byte constants for the smart LED
// UART bit encoder. No dependencies.
package sle_pkg;

	localparam int COLOR_W     = 8;
	localparam int BRIGHT_W    = 9;
	localparam int ORDER_W     = 3;
	localparam int WORD_W      = 24;
	localparam int PROD_W      = COLOR_W + BRIGHT_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int BYTES_PER_PIXEL = 12;
	localparam int BCNT_W      = 4;

	localparam logic [7:0] LINE_BASE   = 8'h08;
	localparam logic [7:0] LINE_HI_CLR = 8'h07;
	localparam logic [7:0] LINE_LO_CLR = 8'hE0;

	localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 9'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PIXEL_ORDER = 2'd0,
		CFG_BRIGHTNESS  = 2'd1
	} cfg_idx_t;

	typedef enum logic [ORDER_W-1:0] {
		ORD_RGB = 3'd0,
		ORD_RBG = 3'd1,
		ORD_GRB = 3'd2,
		ORD_GBR = 3'd3,
		ORD_BRG = 3'd4,
		ORD_BGR = 3'd5
	} order_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// Two LED bits to one UART byte; a clear bit widens its pulse.
	function automatic logic [7:0] encode_pair(input logic [1:0] pair);
		logic [7:0] x;
		x = LINE_BASE;
		if (!pair[1])
			x = x | LINE_HI_CLR;
		if (!pair[0])
			x = x | LINE_LO_CLR;
		return x;
	endfunction

endpackage

// File: design/sle_front.sv
`timescale 1ns / 1ps
// Front end: accepts pixels, scales each color by brightness and packs the
// 24-bit word in the selected order. Depends on sle_pkg.
module sle_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sle_pkg::COLOR_W-1:0]   blue,
	input  logic [sle_pkg::COLOR_W-1:0]   green,
	input  logic [sle_pkg::COLOR_W-1:0]   red,
	input  logic                          final_pixel,
	input  logic [sle_pkg::ORDER_W-1:0]   pixel_order,
	input  logic [sle_pkg::BRIGHT_W-1:0]  brightness,
	input  sle_pkg::q_stat_t              q_stat,
	output logic                          push,
	output sle_pkg::q_entry_t             push_data
);
	import sle_pkg::*;

	logic              valid_s1_q;
	logic [PROD_W-1:0] prod_b_s1, prod_g_s1, prod_r_s1;
	logic              last_s1;
	logic [7:0]        sb, sg, sr;
	logic [WORD_W-1:0] word;

	assign push     = valid_s1_q && !q_stat.full;
	assign in_stall = valid_s1_q && q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (!in_stall) begin
			valid_s1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			prod_b_s1 <= PROD_W'(blue)  * PROD_W'(brightness);
			prod_g_s1 <= PROD_W'(green) * PROD_W'(brightness);
			prod_r_s1 <= PROD_W'(red)   * PROD_W'(brightness);
			last_s1   <= final_pixel;
		end
	end

	// product >> 8, saturated at 255
	always_comb begin
		sb = prod_b_s1[PROD_W-1] ? 8'hFF : prod_b_s1[15:8];
		sg = prod_g_s1[PROD_W-1] ? 8'hFF : prod_g_s1[15:8];
		sr = prod_r_s1[PROD_W-1] ? 8'hFF : prod_r_s1[15:8];
		case (pixel_order)
			ORD_RGB: word = {sr, sg, sb};
			ORD_RBG: word = {sr, sb, sg};
			ORD_GRB: word = {sg, sr, sb};
			ORD_GBR: word = {sg, sb, sr};
			ORD_BRG: word = {sb, sr, sg};
			ORD_BGR: word = {sb, sg, sr};
			default: word = '0;
		endcase
	end

	assign push_data.word = word;
	assign push_data.last = last_s1;

endmodule

// File: design/sle_queue.sv
`timescale 1ns / 1ps
// Small FIFO of packed pixel words between front and back.
// Depends on sle_pkg.
module sle_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sle_pkg::q_entry_t push_data,
	input  logic              pop,
	output sle_pkg::q_entry_t head,
	output sle_pkg::q_stat_t  stat
);
	import sle_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_FULL);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: design/sle_back.sv
`timescale 1ns / 1ps
// Back end: walks the queue head two bits at a time, MSB first, and drives
// the registered line-byte output. Depends on sle_pkg.
module sle_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sle_pkg::q_entry_t head,
	input  sle_pkg::q_stat_t  q_stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        line_byte,
	output logic              pixel_done,
	output logic              frame_done
);
	import sle_pkg::*;

	localparam logic [BCNT_W-1:0] CNT_LAST = BCNT_W'(BYTES_PER_PIXEL - 1);

	logic [BCNT_W-1:0] cnt_q;
	logic              out_valid_q;
	logic [7:0]        line_byte_q;
	logic              pixel_done_q, frame_done_q;
	logic              advance, end_byte;
	logic [4:0]        bit_idx;
	logic [1:0]        pair;

	assign advance  = !q_stat.empty && (!out_valid_q || !out_stall);
	assign end_byte = (cnt_q == CNT_LAST);
	assign pop      = advance && end_byte;
	assign bit_idx  = 5'(WORD_W - 1) - {cnt_q, 1'b0};
	assign pair     = head.word[bit_idx -: 2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				cnt_q <= end_byte ? '0 : cnt_q + 1'b1;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_byte_q  <= encode_pair(pair);
			pixel_done_q <= end_byte;
			frame_done_q <= end_byte && head.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_byte  = line_byte_q;
	assign pixel_done = pixel_done_q;
	assign frame_done = frame_done_q;

endmodule

// File: design/smart_led_uart_bit_encoder_core.sv
`timescale 1ns / 1ps
// Smart LED UART bit encoder, top level. Uses sle_pkg, sle_front, sle_queue, sle_back.
// A pixel goes from the front product register through the queue to the registered line byte.
// Throughput: one line byte per cycle from the output serializer, unless stalled or empty.
// The front takes a new pixel while the back still serializes earlier ones.
// Reset (arst_n low, asynchronous) empties the pipeline and queue, pixel_order 0, brightness 256.
module smart_led_uart_bit_encoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [sle_pkg::COLOR_W-1:0]     blue,
	input  logic [sle_pkg::COLOR_W-1:0]     green,
	input  logic [sle_pkg::COLOR_W-1:0]     red,
	input  logic                            final_pixel,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      line_byte,
	output logic                            pixel_done,
	output logic                            frame_done,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sle_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sle_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sle_pkg::*;

	logic [ORDER_W-1:0]  pixel_order_q;
	logic [BRIGHT_W-1:0] brightness_q;
	q_stat_t             q_stat;
	q_entry_t            push_data, head;
	logic                push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_order_q <= '0;
			brightness_q  <= BRIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PIXEL_ORDER: pixel_order_q <= cfg_data[ORDER_W-1:0];
				CFG_BRIGHTNESS:  brightness_q  <= cfg_data[BRIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	sle_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.final_pixel (final_pixel),
		.pixel_order (pixel_order_q),
		.brightness  (brightness_q),
		.q_stat      (q_stat),
		.push        (push),
		.push_data   (push_data)
	);

	sle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	sle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_byte  (line_byte),
		.pixel_done (pixel_done),
		.frame_done (frame_done)
	);

`ifndef ASSERT_OFF
	a_frame_implies_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> pixel_done)
		else $error("frame_done without pixel_done");

	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.empty && q_stat.full))
		else $error("queue both empty and full");

	a_pop_ends_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid && pixel_done)
		else $error("pixel retired without its last line byte");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");
`endif

endmodule

// File: tb/smart_led_uart_bit_encoder_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for smart_led_uart_bit_encoder_core: scaled and reordered pixels
// are predicted as twelve line bytes each and compared against the output stream.
// Depends on sle_pkg and the core RTL only.
module smart_led_uart_bit_encoder_core_test;
	import sle_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RAND_PHASES  = 10;
	localparam int RAND_PER_PHASE = 10;

	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic               final_pixel;
	} pixel_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       pixel_done;
		logic       frame_done;
	} line_rec_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [COLOR_W-1:0]    blue = '0;
	logic [COLOR_W-1:0]    green = '0;
	logic [COLOR_W-1:0]    red = '0;
	logic                  final_pixel = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            line_byte;
	logic                  pixel_done;
	logic                  frame_done;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow copies of the block's registers
	logic [ORDER_W-1:0]  order_reg = ORD_RGB;
	logic [BRIGHT_W-1:0] bright_reg = BRIGHT_RESET;

	pixel_t    pixels_pending[$];
	line_rec_t line_bytes_due[$];
	logic      in_taken = 1'b0;
	int        mismatches = 0;
	int        idle_cycles = 0;
	int        gap_left = 0;
	int        burst_left = 1;
	int        stall_mode = 0;
	int        stall_mode_left = 0;
	int        stall_tick = 0;

	smart_led_uart_bit_encoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.blue       (blue),
		.green      (green),
		.red        (red),
		.final_pixel(final_pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_byte  (line_byte),
		.pixel_done (pixel_done),
		.frame_done (frame_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 40)
			$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic logic [COLOR_W-1:0] scale_color(input logic [COLOR_W-1:0] v);
		logic [PROD_W-1:0] prod;
		logic [BRIGHT_W-1:0] shifted;
		prod = PROD_W'(v) * PROD_W'(bright_reg);
		shifted = prod[PROD_W-1:8];
		return (shifted > 9'd255) ? 8'hFF : shifted[7:0];
	endfunction

	function automatic void predict_line_bytes(input pixel_t px);
		logic [COLOR_W-1:0] b, g, r;
		logic [WORD_W-1:0] word;
		line_rec_t rec;
		b = scale_color(px.blue);
		g = scale_color(px.green);
		r = scale_color(px.red);
		case (order_reg)
			ORD_RGB: word = {r, g, b};
			ORD_RBG: word = {r, b, g};
			ORD_GRB: word = {g, r, b};
			ORD_GBR: word = {g, b, r};
			ORD_BRG: word = {b, r, g};
			ORD_BGR: word = {b, g, r};
			default: word = '0;
		endcase
		for (int k = 0; k < BYTES_PER_PIXEL; k++) begin
			rec.line_byte = LINE_BASE;
			if (!word[WORD_W-1])
				rec.line_byte = rec.line_byte | LINE_HI_CLR;
			if (!word[WORD_W-2])
				rec.line_byte = rec.line_byte | LINE_LO_CLR;
			rec.pixel_done = (k == BYTES_PER_PIXEL - 1);
			rec.frame_done = rec.pixel_done && px.final_pixel;
			line_bytes_due.push_back(rec);
			word = word << 2;
		end
	endfunction

	// Pixel driver: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		logic   nv;
		pixel_t nx;
		nv = in_valid;
		nx = '{blue, green, red, final_pixel};
		if (arst_n && (!in_valid || in_taken)) begin
			nv = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
			end else if (pixels_pending.size() != 0) begin
				nx = pixels_pending.pop_front();
				nv = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 10);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		in_valid    <= nv;
		blue        <= nx.blue;
		green       <= nx.green;
		red         <= nx.red;
		final_pixel <= nx.final_pixel;
	end

	// Output stall pattern: switches between free, light, heavy and periodic.
	always @(negedge clk) begin
		logic s;
		if (stall_mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_mode_left = $urandom_range(8, 60);
		end else begin
			stall_mode_left--;
		end
		case (stall_mode)
			0: s = 1'b0;
			1: s = ($urandom_range(0, 3) == 0);
			2: s = ($urandom_range(0, 3) != 0);
			default: s = ((stall_tick % 5) < 2);
		endcase
		stall_tick++;
		out_stall <= s;
	end

	// Monitor: predict on pixel transactions, check on line byte transactions.
	always @(posedge clk) begin
		line_rec_t want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				predict_line_bytes('{blue, green, red, final_pixel});
			if (out_valid && !out_stall) begin
				if (line_bytes_due.size() == 0) begin
					report_mismatch("line byte with nothing due", line_byte, 0);
				end else begin
					want = line_bytes_due.pop_front();
					if (line_byte !== want.line_byte)
						report_mismatch("line_byte", line_byte, want.line_byte);
					if (pixel_done !== want.pixel_done)
						report_mismatch("pixel_done", pixel_done, want.pixel_done);
					if (frame_done !== want.frame_done)
						report_mismatch("frame_done", frame_done, want.frame_done);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_PIXEL_ORDER)
			order_reg = data[ORDER_W-1:0];
		else if (idx == CFG_BRIGHTNESS)
			bright_reg = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
			input logic f);
		pixels_pending.push_back('{b, g, r, f});
	endtask

	function automatic logic [7:0] rand_color();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic drain_pipeline();
		while (pixels_pending.size() != 0 || in_valid || line_bytes_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [BRIGHT_W-1:0] bright;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: RGB, full brightness
		add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		add_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
		add_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
		add_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
		add_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
		add_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
		add_pixel(8'h01, 8'h80, 8'h7F, 1'b1);
		add_pixel(8'hFE, 8'h01, 8'hC3, 1'b0);
		add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		drain_pipeline();

		// brightness above full saturates; writes to spare indexes must be ignored
		write_reg(CFG_PIXEL_ORDER, {6'h2A, ORD_BGR});
		write_reg(CFG_BRIGHTNESS, 9'd511);
		write_reg(CFG_SPARE_LO, 9'h000);
		write_reg(CFG_SPARE_HI, 9'h1FF);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		add_pixel(8'h80, 8'h81, 8'h7F, 1'b0);
		add_pixel(8'h01, 8'h02, 8'h03, 1'b1);
		drain_pipeline();

		// unused colour orders give an all-zero word
		write_reg(CFG_PIXEL_ORDER, 9'h1FE);
		write_reg(CFG_BRIGHTNESS, BRIGHT_RESET);
		add_pixel(8'hFF, 8'hAA, 8'h12, 1'b1);
		drain_pipeline();
		write_reg(CFG_PIXEL_ORDER, 9'h007);
		write_reg(CFG_BRIGHTNESS, 9'd0);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		add_pixel(8'h12, 8'h34, 8'h56, 1'b1);
		drain_pipeline();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph % 2 == 0) begin
				case ((ph / 2) % 6)
					0: bright = 9'd0;
					1: bright = 9'd1;
					2: bright = 9'd255;
					3: bright = 9'd256;
					4: bright = 9'd257;
					default: bright = 9'd511;
				endcase
			end else begin
				bright = 9'($urandom_range(0, 511));
			end
			write_reg(CFG_PIXEL_ORDER,
				{6'($urandom_range(0, 63)), 3'((ph < 8) ? ph : $urandom_range(0, 7))});
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
					9'($urandom_range(0, 511)));
			write_reg(CFG_BRIGHTNESS, bright);
			for (int n = 0; n < RAND_PER_PHASE; n++)
				add_pixel(rand_color(), rand_color(), rand_color(), $urandom_range(0, 5) == 0);
			drain_pipeline();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (line_bytes_due.size() != 0)
			report_mismatch("line bytes never produced", line_bytes_due.size(), 0);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: smart_led_uart_bit_encoder_core.f
design/sle_pkg.sv
design/sle_front.sv
design/sle_queue.sv
design/sle_back.sv
design/smart_led_uart_bit_encoder_core.sv
tb/smart_led_uart_bit_encoder_core_test.sv
